### hw/rtl/drbt_pkg.sv
// ----------------------------------------------------------------------------
// drbt_pkg
// Shared constants, command types and helpers for the dirty region tracker.
// ----------------------------------------------------------------------------
package drbt_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;

  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int OP_W      = 2;
  localparam int COL_IN_W  = 6;
  localparam int ROW_IN_W  = 5;
  localparam int ROW_OUT_W = 5;
  localparam int BITS_W    = 64;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BITS_W-1:0] mask;
    logic [ROW_W-1:0]  top;
    logic [ROW_W-1:0]  bottom;
  } cmd_t;

  typedef struct packed {
    logic push;
  } q_wr_t;

  function automatic logic [COL_IN_W-1:0] clamp_col(input logic [COL_IN_W-1:0] v);
    logic [COL_IN_W-1:0] lim;
    lim = COL_IN_W'(GRID_COLS - 1);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [ROW_IN_W-1:0] clamp_row(input logic [ROW_IN_W-1:0] v);
    logic [ROW_IN_W-1:0] lim;
    lim = ROW_IN_W'(GRID_ROWS - 1);
    return (v > lim) ? lim : v;
  endfunction

endpackage

### hw/rtl/drbt_front.sv
// ----------------------------------------------------------------------------
// drbt_front
// Accepts input transactions, clamps coordinates, builds the column mask and
// queues a command; drops unknown ops and empty rectangles.
// ----------------------------------------------------------------------------
module drbt_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [drbt_pkg::OP_W-1:0]       op,
  input  logic [drbt_pkg::COL_IN_W-1:0]   left,
  input  logic [drbt_pkg::ROW_IN_W-1:0]   top,
  input  logic [drbt_pkg::COL_IN_W-1:0]   right,
  input  logic [drbt_pkg::ROW_IN_W-1:0]   bottom,
  input  logic                            q_full,
  output drbt_pkg::q_wr_t                 q_wr,
  output drbt_pkg::cmd_t                  cmd
);

  logic [drbt_pkg::COL_IN_W-1:0] left_c;
  logic [drbt_pkg::COL_IN_W-1:0] right_c;
  logic [drbt_pkg::ROW_IN_W-1:0] top_c;
  logic [drbt_pkg::ROW_IN_W-1:0] bottom_c;
  logic [drbt_pkg::BITS_W-1:0]   mask;
  logic                          keep;

  always_comb begin
    left_c   = drbt_pkg::clamp_col(left);
    right_c  = drbt_pkg::clamp_col(right);
    top_c    = drbt_pkg::clamp_row(top);
    bottom_c = drbt_pkg::clamp_row(bottom);
    mask     = ({drbt_pkg::BITS_W{1'b1}} >> (drbt_pkg::COL_IN_W'(drbt_pkg::BITS_W - 1) - right_c))
             & ({drbt_pkg::BITS_W{1'b1}} << left_c);
    cmd.mask   = mask;
    cmd.top    = drbt_pkg::ROW_W'(top_c);
    cmd.bottom = drbt_pkg::ROW_W'(bottom_c);
    cmd.kind   = drbt_pkg::CMD_CLEAR;
    keep       = 1'b0;
    case (op)
      drbt_pkg::OP_CLEAR: begin
        cmd.kind = drbt_pkg::CMD_CLEAR;
        keep     = 1'b1;
      end
      drbt_pkg::OP_MARK: begin
        cmd.kind = drbt_pkg::CMD_MARK;
        keep     = (left_c <= right_c) && (top_c <= bottom_c);
      end
      drbt_pkg::OP_REPORT: begin
        cmd.kind = drbt_pkg::CMD_REPORT;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready  = !q_full;
  assign q_wr.push = in_valid && !q_full && keep;

endmodule

### hw/rtl/drbt_queue.sv
// ----------------------------------------------------------------------------
// drbt_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module drbt_queue (
  input  logic            clk,
  input  logic            rst,
  input  drbt_pkg::q_wr_t q_wr,
  input  drbt_pkg::cmd_t  wr_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output drbt_pkg::cmd_t  head
);

  drbt_pkg::cmd_t                 entries [drbt_pkg::QUEUE_DEPTH];
  logic [drbt_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [drbt_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [drbt_pkg::QUEUE_AW:0]    count;

  assign full  = (count == (drbt_pkg::QUEUE_AW + 1)'(drbt_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        entries[wr_ptr] <= wr_cmd;
        wr_ptr          <= wr_ptr + drbt_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + drbt_pkg::QUEUE_AW'(1);
      end
      if (q_wr.push && !pop) begin
        count <= count + (drbt_pkg::QUEUE_AW + 1)'(1);
      end else if (pop && !q_wr.push) begin
        count <= count - (drbt_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

### hw/rtl/drbt_back.sv
// ----------------------------------------------------------------------------
// drbt_back
// Holds the row bitmaps and executes queued commands: clear on dispatch, mark
// and report one row per cycle, report while the result register is free.
// ----------------------------------------------------------------------------
module drbt_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  drbt_pkg::cmd_t                     head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [drbt_pkg::ROW_OUT_W-1:0]     row_index,
  output logic [drbt_pkg::BITS_W-1:0]        row_bits,
  output logic                               found,
  output logic                               last
);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_MARK   = 3'b010,
    B_REPORT = 3'b100
  } back_state_t;

  localparam logic [drbt_pkg::ROW_W-1:0] ROW_LAST = drbt_pkg::ROW_W'(drbt_pkg::GRID_ROWS - 1);

  back_state_t                      state;
  logic [drbt_pkg::BITS_W-1:0]      rows [drbt_pkg::GRID_ROWS];
  logic [drbt_pkg::GRID_ROWS-1:0]   dirty;
  logic [drbt_pkg::ROW_W-1:0]       row;
  logic [drbt_pkg::ROW_W-1:0]       row_end;
  logic [drbt_pkg::BITS_W-1:0]      mask;
  logic                             out_free;
  logic                             last_dirty;
  logic                             emit;

  assign pop        = (state == B_IDLE) && !q_empty;
  assign out_free   = !out_valid || out_ready;
  assign last_dirty = ((dirty >> row) >> 1) == '0;
  assign emit       = (state == B_REPORT) && out_free && (dirty[row] || (row == ROW_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      dirty     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            case (head.kind)
              drbt_pkg::CMD_CLEAR: begin
                dirty <= '0;
              end
              drbt_pkg::CMD_MARK: begin
                row     <= head.top;
                row_end <= head.bottom;
                mask    <= head.mask;
                state   <= B_MARK;
              end
              drbt_pkg::CMD_REPORT: begin
                row   <= '0;
                state <= B_REPORT;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_MARK: begin
          rows[row]  <= dirty[row] ? (rows[row] | mask) : mask;
          dirty[row] <= 1'b1;
          if (row == row_end) begin
            state <= B_IDLE;
          end else begin
            row <= row + drbt_pkg::ROW_W'(1);
          end
        end
        B_REPORT: begin
          if (out_free) begin
            if (dirty[row]) begin
              row_index <= drbt_pkg::ROW_OUT_W'(row);
              row_bits  <= rows[row];
              found     <= 1'b1;
              last      <= last_dirty;
              if (last_dirty) begin
                state <= B_IDLE;
              end else begin
                row <= row + drbt_pkg::ROW_W'(1);
              end
            end else if (row == ROW_LAST) begin
              row_index <= '0;
              row_bits  <= '0;
              found     <= 1'b0;
              last      <= 1'b1;
              state     <= B_IDLE;
            end else begin
              row <= row + drbt_pkg::ROW_W'(1);
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/dirty_region_bitmap_tracker_top.sv
// ----------------------------------------------------------------------------
// dirty_region_bitmap_tracker_top
// Per-row dirty bitmap tracker: clear, mark rectangle, report dirty rows.
// ----------------------------------------------------------------------------
// Clear is done on dispatch from idle. Mark: after dispatch, one row store
// write per cycle for rows top through bottom. Report: after dispatch, up to
// GRID_ROWS rows, one row read per cycle while the output is not stalled;
// results are registered. Two queued commands hold input off.
// Reset empties the queue and the output register and marks every row clean.
// ----------------------------------------------------------------------------
module dirty_region_bitmap_tracker_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [drbt_pkg::OP_W-1:0]        op,
  input  logic [drbt_pkg::COL_IN_W-1:0]    left,
  input  logic [drbt_pkg::ROW_IN_W-1:0]    top,
  input  logic [drbt_pkg::COL_IN_W-1:0]    right,
  input  logic [drbt_pkg::ROW_IN_W-1:0]    bottom,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [drbt_pkg::ROW_OUT_W-1:0]   row_index,
  output logic [drbt_pkg::BITS_W-1:0]      row_bits,
  output logic                             found,
  output logic                             last
);

  drbt_pkg::q_wr_t q_wr;
  drbt_pkg::cmd_t  wr_cmd;
  drbt_pkg::cmd_t  head;
  logic            q_full;
  logic            q_empty;
  logic            pop;

  drbt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .left     (left),
    .top      (top),
    .right    (right),
    .bottom   (bottom),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .cmd      (wr_cmd)
  );

  drbt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (pop),
    .empty  (q_empty),
    .head   (head)
  );

  drbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_index (row_index),
    .row_bits  (row_bits),
    .found     (found),
    .last      (last)
  );

  a_empty_report_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> last)
    else $error("empty report result without last");

  a_empty_report_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (row_bits == '0 && row_index == '0))
    else $error("empty report result carries data");

  a_found_row_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (row_bits != '0))
    else $error("reported row has no dirty bits");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_wr.push)
    else $error("command pushed into full queue");

endmodule
